// ===== sv/sha256_stream_hasher_defines.svh =====
// assertion macros for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sha256_pkg.sv =====
// package with sha256 constants, types and round functions
`default_nettype none
package sha256_pkg;
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] START_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_COMPRESS, ST_ADD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } comp_ctrl_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction
   function automatic logic [31:0] ssig0(input logic [31:0] x);
      ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction
   function automatic logic [31:0] ssig1(input logic [31:0] x);
      ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction
   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction
   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction
endpackage
`default_nettype wire

// ===== sv/sha256_if.sv =====
// valid/ready channel interfaces
`default_nettype none
interface sha256_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic byte_valid;
   logic end_of_message;
   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] digest_word;
   logic [2:0] word_index;
   logic last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== sv/sha256_compress.sv =====
// 64-round compression with message schedule held in a 16-word memory
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha256_compress
   import sha256_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire comp_ctrl_type ctrl,
   input  wire logic          wr_en,
   input  wire logic [3:0]    wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [255:0]  h_in,
   output logic              done,
   output logic [255:0]      v_out
);
   // schedule window in a memory: each round reads w-16, w-15, w-7 in turn; w-2 kept in registers
   logic [31:0] wmem [16];
   logic [31:0] rd_ff;
   logic [3:0]  rd_addr;
   logic [5:0]  round_ff, round_in;
   logic [1:0]  phase_ff, phase_in;
   logic        run_ff, run_in;
   logic [31:0] w16_ff, w15_ff;
   logic [31:0] wm1_ff, wm2_ff;
   logic [31:0] v_ff [8];
   logic [31:0] wt, t1, t2;
   logic        mwr;
   logic [3:0]  maddr;
   logic [31:0] mdata;

   always_comb begin
      case (phase_ff)
         2'd0: rd_addr = round_ff[3:0];
         2'd1: rd_addr = round_ff[3:0] + 4'd1;
         default: rd_addr = round_ff[3:0] + 4'd9;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= wmem[rd_addr];
      if (mwr) wmem[maddr] <= mdata;
   end

   always_comb begin
      if (round_ff < 6'd16) wt = w16_ff;
      else wt = w16_ff + ssig0(w15_ff) + rd_ff + ssig1(wm2_ff);
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[round_ff] + wt;
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      mwr = wr_en || (run_ff && phase_ff == 2'd3);
      maddr = wr_en ? wr_addr : round_ff[3:0];
      mdata = wr_en ? wr_data : wt;
      run_in = run_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      done = 1'b0;
      if (ctrl.start && !run_ff) begin
         run_in = 1'b1;
         phase_in = 2'd0;
         round_in = 6'd0;
      end else if (run_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               run_in = 1'b0;
               done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         phase_ff <= 2'd0;
         round_ff <= 6'd0;
      end else begin
         run_ff <= run_in;
         phase_ff <= phase_in;
         round_ff <= round_in;
      end
      if (phase_ff == 2'd1) w16_ff <= rd_ff;
      if (phase_ff == 2'd2) w15_ff <= rd_ff;
      if (phase_ff == 2'd3 && run_ff) begin
         wm2_ff <= wm1_ff;
         wm1_ff <= wt;
      end
      if (ctrl.start && !run_ff) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_in[255 - 32*i -: 32];
      end else if (run_ff && phase_ff == 2'd3) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) v_out[255 - 32*i -: 32] = v_ff[i];
   end

   `SHA_ASSERT_NEXT(a_no_restart, clock, reset, run_ff && !done, run_ff)
   `SHA_ASSERT_IMPL(a_no_write_run, clock, reset, run_ff, !wr_en)
   `SHA_ASSERT_IMPL(a_busy_match, clock, reset, ctrl.busy, run_ff || ctrl.start)
endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
// byte-serial sha256 hasher, top level
// a message byte is taken only in idle; every 64th byte starts a compression
// (rounds run on the schedule memory port, with load before and add after)
// end of message pads one byte a cycle between compressions, then emits eight
// words one per cycle while rsp is ready; digest latency depends on padding length
// synchronous reset loads the initial hash values and clears counts
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   state_type   state_ff, state_in;
   logic [31:0] h_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] word_ff;
   logic        fin_ff, fin_in;
   logic        tail_ff, tail_in;
   logic        pad_mode_ff, pad_mode_in;
   logic [2:0]  idx_ff, idx_in;
   logic        wr_en;
   logic [7:0]  wr_byte;
   logic [31:0] word_val;
   logic        done;
   logic [255:0] h_vec, v_vec;
   comp_ctrl_type ctrl;
   logic        accept;
   logic        add_en;
   logic        clear;
   logic [63:0] bits;
   logic        mem_wr;
   logic [3:0]  mem_addr;
   logic [31:0] mem_data;

   assign req.ready = state_ff == ST_IDLE;
   assign accept = req.valid && req.ready;
   assign bits = {len_ff[60:0], 3'b000};

   always_comb begin
      for (int i = 0; i < 8; i++) h_vec[255 - 32*i -: 32] = h_ff[i];
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      fin_in = fin_ff;
      tail_in = tail_ff;
      pad_mode_in = pad_mode_ff;
      idx_in = idx_ff;
      wr_en = 1'b0;
      wr_byte = 8'd0;
      add_en = 1'b0;
      clear = 1'b0;
      ctrl.start = 1'b0;
      ctrl.busy = state_ff == ST_COMPRESS;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.byte_valid) begin
                  wr_en = 1'b1;
                  wr_byte = req.data_byte;
                  fill_in = fill_ff + 6'd1;
                  len_in = len_ff + 64'd1;
               end
               if (req.end_of_message) begin
                  fin_in = 1'b1;
                  pad_mode_in = 1'b1;
               end
               if (req.byte_valid && fill_ff == 6'd63) begin
                  state_in = ST_COMPRESS;
                  ctrl.start = 1'b1;
               end else if (req.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (fin_ff) begin
               wr_byte = PAD_BYTE;
               fin_in = 1'b0;
               tail_in = fill_ff < 6'd56;
            end else if (tail_ff && fill_ff >= 6'd56) begin
               wr_byte = bits[63 - 8*fill_ff[2:0] -: 8];
            end else begin
               wr_byte = 8'd0;
            end
            if (fill_ff == 6'd63) begin
               state_in = ST_COMPRESS;
               ctrl.start = 1'b1;
            end
         end
         ST_COMPRESS: begin
            if (done) state_in = ST_ADD;
         end
         ST_ADD: begin
            add_en = 1'b1;
            if (!pad_mode_ff) begin
               state_in = ST_IDLE;
            end else if (tail_ff && !fin_ff) begin
               state_in = ST_EMIT;
               idx_in = 3'd0;
            end else begin
               state_in = ST_PAD;
               tail_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  clear = 1'b1;
                  fill_in = 6'd0;
                  len_in = 64'd0;
                  fin_in = 1'b0;
                  tail_in = 1'b0;
                  pad_mode_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= 6'd0;
         len_ff <= 64'd0;
         fin_ff <= 1'b0;
         tail_ff <= 1'b0;
         pad_mode_ff <= 1'b0;
         idx_ff <= 3'd0;
         for (int i = 0; i < 8; i++) h_ff[i] <= START_H[i];
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         fin_ff <= fin_in;
         tail_ff <= tail_in;
         pad_mode_ff <= pad_mode_in;
         idx_ff <= idx_in;
         if (add_en) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_vec[255 - 32*i -: 32];
         end else if (clear) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= START_H[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (fill_ff[1:0] == 2'd0) word_ff <= {wr_byte, 24'd0};
         else word_ff <= word_val;
      end
   end

   always_comb begin
      word_val = word_ff;
      word_val[31 - 8*fill_ff[1:0] -: 8] = wr_byte;
   end

   assign mem_wr = wr_en && fill_ff[1:0] == 2'd3;
   assign mem_addr = fill_ff[5:2];
   assign mem_data = word_val;

   sha256_compress u_comp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (mem_data),
      .h_in    (h_vec),
      .done    (done),
      .v_out   (v_vec)
   );

   assign rsp.valid = state_ff == ST_EMIT;
   assign rsp.digest_word = h_ff[idx_ff];
   assign rsp.word_index = idx_ff;
   assign rsp.last_word = idx_ff == 3'd7;

   `SHA_ASSERT_IMPL(a_emit_idle, clock, reset, rsp.valid, !req.ready)
   `SHA_ASSERT_IMPL(a_last_seven, clock, reset, rsp.valid && rsp.last_word, rsp.word_index == 3'd7)
   `SHA_ASSERT_NEXT(a_start_busy, clock, reset, ctrl.start, state_ff == ST_COMPRESS)
   `SHA_ASSERT_NEXT(a_emit_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.word_index))
endmodule
`default_nettype wire

// ===== verif/sha256_tb_if.sv =====
// note: the channel interfaces come from the rtl file sha256_if.sv and are reused as they are
// testbench-side helper package holding the digest scoreboard class
package sha256_tb_pkg;
   import sha256_pkg::*;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   class digest_scoreboard;
      logic [31:0] hash_state [8];
      logic [31:0] block_words [16];
      int unsigned fill_bytes;
      logic [63:0] byte_count;
      digest_item_type pending_words [$];
      int error_count;

      function new();
         error_count = 0;
         clear_message();
      endfunction

      function void clear_message();
         for (int i = 0; i < 8; i++) hash_state[i] = START_H[i];
         for (int i = 0; i < 16; i++) block_words[i] = '0;
         fill_bytes = 0;
         byte_count = '0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
         for (int i = 0; i < 16; i++) w[i] = block_words[i];
         for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
               + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
               + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
         a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
         e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
         end
         hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
         hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
      endfunction

      function void absorb_byte(logic [7:0] b);
         int unsigned word_sel;
         int unsigned lane;
         word_sel = fill_bytes >> 2;
         lane = fill_bytes & 3;
         if (lane == 0) block_words[word_sel] = '0;
         block_words[word_sel][31 - 8*lane -: 8] = b;
         fill_bytes++;
         if (fill_bytes == 64) begin
            compress_block();
            fill_bytes = 0;
         end
      endfunction

      function void note_request(logic [7:0] data_byte, logic byte_valid,
                                 logic end_of_message);
         logic [63:0] bit_length;
         digest_item_type word_item;
         if (byte_valid) begin
            absorb_byte(data_byte);
            byte_count++;
         end
         if (!end_of_message) return;
         bit_length = byte_count << 3;
         absorb_byte(PAD_BYTE);
         while (fill_bytes != 56) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(bit_length[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            word_item.digest_word = hash_state[i];
            word_item.word_index = 3'(i);
            word_item.last_word = (i == 7);
            pending_words.push_back(word_item);
         end
         clear_message();
      endfunction

      function void check_digest_word(digest_item_type got);
         digest_item_type want;
         if (pending_words.size() == 0) begin
            $error("unexpected digest word %h", got.digest_word);
            error_count++;
            return;
         end
         want = pending_words.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
            error_count++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            error_count++;
         end
         if (got.last_word !== want.last_word) begin
            $error("last_word expected %0d actual %0d", want.last_word, got.last_word);
            error_count++;
         end
      endfunction
   endclass
endpackage

// ===== verif/tb.sv =====
// testbench top for the sha256 stream hasher
module tb;
   import sha256_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int send_idle_pct = 18;
   int recv_idle_pct = 63;
   int sent_bytes;
   digest_scoreboard digests;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_stream_hasher DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.data_byte = '0;
      req.byte_valid = 1'b0;
      req.end_of_message = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp.valid && rsp.ready)
            digests.check_digest_word({rsp.digest_word, rsp.word_index, rsp.last_word});
      end
   end

   task automatic send_item(logic [7:0] data_byte, logic byte_valid, logic end_of_message);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= data_byte;
      req.byte_valid <= byte_valid;
      req.end_of_message <= end_of_message;
      do @(posedge clock); while (!req.ready);
      digests.note_request(data_byte, byte_valid, end_of_message);
      if (byte_valid || end_of_message) sent_bytes++;
   endtask

   task automatic send_message(int length, int mode);
      logic [7:0] b;
      for (int i = 0; i < length; i++) begin
         case (mode)
            0: b = 8'(i);
            1: b = 8'hff;
            2: b = 8'h00;
            default: b = 8'($urandom_range(255));
         endcase
         if (mode == 3 && $urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         if (i == length - 1 && $urandom_range(1)) begin
            send_item(b, 1'b1, 1'b1);
            return;
         end
         send_item(b, 1'b1, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(9);
      if (roll < 4) return $urandom_range(8);
      if (roll < 8) return $urandom_range(54, 66);
      return $urandom_range(110, 130);
   endfunction

   task automatic run_phase(int target);
      int start_count;
      start_count = sent_bytes;
      while (sent_bytes - start_count < target) send_message(pick_length(), 3);
   endtask

   initial begin
      digests = new();
      sent_bytes = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty message, idle item, short messages, padding boundaries
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b1);
      send_message(3, 0);
      send_message(2, 1);
      send_message(2, 2);
      send_message(55, 3);
      send_message(56, 3);
      send_message(64, 3);
      run_phase(50);
      send_idle_pct = 63;
      recv_idle_pct = 18;
      run_phase(50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(50);
      req.valid <= 1'b0;
      while (digests.pending_words.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (digests.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+sv
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_compress.sv
sv/sha256_stream_hasher.sv
verif/sha256_tb_if.sv
verif/tb.sv
